[sv/wildcard_name_matcher_assert.svh]
// Assertion macros for the wildcard name matcher.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef WILDCARD_NAME_MATCHER_ASSERT_SVH
`define WILDCARD_NAME_MATCHER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WNM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wildcard_name_matcher: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define WNM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wildcard_name_matcher: next-cycle check failed");

`endif

[sv/wnm_pkg.sv]
// Shared constants, register index codes and the case fold helper
// for the wildcard name matcher. No dependencies.
`timescale 1ns / 1ps

package wnm_pkg;

  localparam int PatternMaxDef = 32;
  localparam int CharW         = 8;
  localparam int CfgDataW      = 64;
  localparam int CfgIdxW       = 3;
  localparam int NumPatRegs    = 4;
  localparam int LenRegW       = 6;

  localparam logic [CharW-1:0] ChStar  = 8'h2A;
  localparam logic [CharW-1:0] ChQuest = 8'h3F;
  localparam logic [CharW-1:0] ChUpA   = 8'h41;
  localparam logic [CharW-1:0] ChUpZ   = 8'h5A;
  localparam logic [CharW-1:0] CaseGap = 8'h20;

  localparam logic [CfgDataW-1:0] PatReset0 = 64'd42;
  localparam logic [LenRegW-1:0]  LenReset  = 6'd1;
  localparam logic                FoldReset = 1'b1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PAT_0_7   = 3'd0,
    CFG_PAT_8_15  = 3'd1,
    CFG_PAT_16_23 = 3'd2,
    CFG_PAT_24_31 = 3'd3,
    CFG_LENGTH    = 3'd4,
    CFG_CASE_FOLD = 3'd5
  } cfg_idx_t;

  function automatic logic [CharW-1:0] fold_char(input logic [CharW-1:0] c,
                                                 input logic fold_en);
    logic [CharW-1:0] r;
    r = c;
    if (fold_en && (c >= ChUpA) && (c <= ChUpZ)) begin
      r = c + CaseGap;
    end
    return r;
  endfunction

endpackage

[sv/wnm_closure.sv]
// Star closure over the position vector as a parallel prefix network.
// Depends on nothing but its parameter.
`timescale 1ns / 1ps

module wnm_closure #(
  parameter int W = 33
) (
  input  logic [W-1:0] vec_in,
  input  logic [W-1:0] prop,    // bit j may be set from bit j-1
  output logic [W-1:0] vec_out
);

  localparam int Levels = (W > 1) ? $clog2(W) : 1;

  always_comb begin
    logic [W-1:0] g;
    logic [W-1:0] p;
    logic [W-1:0] g_o;
    logic [W-1:0] p_o;
    g = vec_in;
    p = prop;
    for (int lv = 0; lv < Levels; lv++) begin
      g_o = g;
      p_o = p;
      for (int j = 0; j < W; j++) begin
        if (j >= (1 << lv)) begin
          g[j] = g_o[j] | (p_o[j] & g_o[j - (1 << lv)]);
          p[j] = p_o[j] & p_o[j - (1 << lv)];
        end
      end
    end
    vec_out = g;
  end

endmodule

[sv/wnm_cfg.sv]
// Configuration registers and per-position pattern decode.
// Depends on wnm_pkg and wnm_closure.
`timescale 1ns / 1ps

module wnm_cfg import wnm_pkg::*; #(
  parameter int PATTERN_MAX = PatternMaxDef,
  parameter int LW          = $clog2(PATTERN_MAX + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CfgIdxW-1:0]       cfg_index,
  input  logic [CfgDataW-1:0]      cfg_data,
  output logic                     rearm_req,
  output logic                     fold_en,
  output logic [LW-1:0]            len_eff,
  output logic [PATTERN_MAX-1:0]   use_mask,
  output logic [PATTERN_MAX-1:0]   star_mask,
  output logic [PATTERN_MAX-1:0]   quest_mask,
  output logic [CharW-1:0]         pchar [PATTERN_MAX],
  output logic [PATTERN_MAX:0]     rearm_vec
);

  logic [CfgDataW-1:0]            pat_r [NumPatRegs];
  logic [LenRegW-1:0]             len_r;
  logic                           fold_r;
  logic [NumPatRegs*CfgDataW-1:0] pat_flat;
  logic [PATTERN_MAX:0]           seed;
  logic [PATTERN_MAX:0]           prop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r[0] <= PatReset0;
      pat_r[1] <= '0;
      pat_r[2] <= '0;
      pat_r[3] <= '0;
      len_r    <= LenReset;
      fold_r   <= FoldReset;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PAT_0_7:   pat_r[0] <= cfg_data;
        CFG_PAT_8_15:  pat_r[1] <= cfg_data;
        CFG_PAT_16_23: pat_r[2] <= cfg_data;
        CFG_PAT_24_31: pat_r[3] <= cfg_data;
        CFG_LENGTH:    len_r    <= cfg_data[LenRegW-1:0];
        CFG_CASE_FOLD: fold_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Writes to unknown indexes are dropped and do not re-arm.
  always_comb begin
    rearm_req = 1'b0;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PAT_0_7, CFG_PAT_8_15, CFG_PAT_16_23, CFG_PAT_24_31,
        CFG_LENGTH, CFG_CASE_FOLD: rearm_req = 1'b1;
        default:                   rearm_req = 1'b0;
      endcase
    end
  end

  assign fold_en  = fold_r;
  assign pat_flat = {pat_r[3], pat_r[2], pat_r[1], pat_r[0]};

  // Clamp an oversized length to the maximum.
  always_comb begin
    if (len_r > LenRegW'(PATTERN_MAX)) begin
      len_eff = LW'(PATTERN_MAX);
    end else begin
      len_eff = LW'(len_r);
    end
  end

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_pos
    logic [CharW-1:0] raw;
    assign raw           = pat_flat[i*CharW +: CharW];
    assign use_mask[i]   = (LW'(i) < len_eff);
    assign star_mask[i]  = use_mask[i] && (raw == ChStar);
    assign quest_mask[i] = use_mask[i] && (raw == ChQuest);
    assign pchar[i]      = fold_char(raw, fold_r);
  end

  assign seed = {{PATTERN_MAX{1'b0}}, 1'b1};
  assign prop = {star_mask, 1'b0};

  wnm_closure #(.W(PATTERN_MAX + 1)) u_rearm_closure (
    .vec_in  (seed),
    .prop    (prop),
    .vec_out (rearm_vec)
  );

endmodule

[sv/wnm_step.sv]
// One NFA step: position transitions for a character, star closure,
// and the end-of-pattern tap. Depends on wnm_pkg and wnm_closure.
`timescale 1ns / 1ps

module wnm_step import wnm_pkg::*; #(
  parameter int PATTERN_MAX = PatternMaxDef,
  parameter int LW          = $clog2(PATTERN_MAX + 1)
) (
  input  logic [PATTERN_MAX:0]   cur,
  input  logic [CharW-1:0]       name_char,
  input  logic                   fold_en,
  input  logic [LW-1:0]          len_eff,
  input  logic [PATTERN_MAX-1:0] use_mask,
  input  logic [PATTERN_MAX-1:0] star_mask,
  input  logic [PATTERN_MAX-1:0] quest_mask,
  input  logic [CharW-1:0]       pchar [PATTERN_MAX],
  output logic [PATTERN_MAX:0]   nxt,
  output logic                   matched
);

  logic [CharW-1:0]       c_f;
  logic [PATTERN_MAX-1:0] stay;
  logic [PATTERN_MAX-1:0] adv;
  logic [PATTERN_MAX:0]   pre;
  logic [PATTERN_MAX:0]   prop;

  assign c_f = fold_char(name_char, fold_en);

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_move
    logic hit;
    assign hit     = cur[i] && use_mask[i];
    assign stay[i] = hit && star_mask[i];
    assign adv[i]  = hit && !star_mask[i] && (quest_mask[i] || (pchar[i] == c_f));
  end

  assign pre  = {1'b0, stay} | {adv, 1'b0};
  assign prop = {star_mask, 1'b0};

  wnm_closure #(.W(PATTERN_MAX + 1)) u_step_closure (
    .vec_in  (pre),
    .prop    (prop),
    .vec_out (nxt)
  );

  assign matched = nxt[len_eff];

endmodule

[sv/wildcard_name_matcher.sv]
// Top level of the wildcard name matcher: input register, NFA state and
// result register. Depends on wnm_pkg, wnm_cfg, wnm_step and the assert header.
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+-------------------------------
//  in_     | sink      | in_valid/ready   | in_name_char, in_name_end
//  out_    | source    | out_valid/ready  | out_matched (last char only)
//  cfg_    | sink      | cfg_we, no wait  | cfg_index, cfg_data
//
// One character beat per cycle, sustained unless a name-end beat waits for the
// result slot; its result is registered as it leaves the input register.
// The state update is a single pass of the transition and closure logic,
// so the only loop is state_r through wnm_step.
// Reset (rst_n, synchronous) loads the reset pattern "*" and arms the state.
// A stalled result holds a name-end beat and the beats behind it; others flow.
`timescale 1ns / 1ps
`include "wildcard_name_matcher_assert.svh"

module wildcard_name_matcher import wnm_pkg::*; #(
  parameter int PATTERN_MAX = PatternMaxDef
) (
  input  logic                clk,
  input  logic                rst_n,
  // character stream
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CharW-1:0]    in_name_char,
  input  logic                in_name_end,
  // match results
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_matched,
  // configuration writes
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  localparam int LW = $clog2(PATTERN_MAX + 1);

  // Decoded configuration
  logic                   rearm_req;
  logic                   fold_en;
  logic [LW-1:0]          len_eff;
  logic [PATTERN_MAX-1:0] use_mask;
  logic [PATTERN_MAX-1:0] star_mask;
  logic [PATTERN_MAX-1:0] quest_mask;
  logic [CharW-1:0]       pchar [PATTERN_MAX];
  logic [PATTERN_MAX:0]   rearm_vec;

  // Input register
  logic                   s1_valid_r;
  logic                   s1_valid_nxt;
  logic [CharW-1:0]       s1_char_r;
  logic                   s1_end_r;
  logic                   s1_adv;
  logic                   in_fire;

  // NFA state: fresh_r means "start of a name", state then reads as rearm_vec
  logic [PATTERN_MAX:0]   state_r;
  logic                   fresh_r;
  logic [PATTERN_MAX:0]   cur;
  logic [PATTERN_MAX:0]   step_nxt;
  logic                   step_match;

  // Result register
  logic                   out_valid_r;
  logic                   out_matched_r;
  logic                   out_free;

  wnm_cfg #(.PATTERN_MAX(PATTERN_MAX), .LW(LW)) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .rearm_req  (rearm_req),
    .fold_en    (fold_en),
    .len_eff    (len_eff),
    .use_mask   (use_mask),
    .star_mask  (star_mask),
    .quest_mask (quest_mask),
    .pchar      (pchar),
    .rearm_vec  (rearm_vec)
  );

  // Handshake: a name-end beat needs a free result slot, others never wait.
  assign out_free     = !out_valid_r || out_ready;
  assign s1_adv       = s1_valid_r && (!s1_end_r || out_free);
  assign in_ready     = !s1_valid_r || s1_adv;
  assign in_fire      = in_valid && in_ready;
  assign s1_valid_nxt = in_fire || (s1_valid_r && !s1_adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // Payload: load on every accepted beat, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_char_r <= in_name_char;
      s1_end_r  <= in_name_end;
    end
  end

  // A fresh name starts from position zero plus its star closure, taken from
  // the current pattern, so a re-arm after a config write sees the new pattern.
  assign cur = fresh_r ? rearm_vec : state_r;

  wnm_step #(.PATTERN_MAX(PATTERN_MAX), .LW(LW)) u_step (
    .cur        (cur),
    .name_char  (s1_char_r),
    .fold_en    (fold_en),
    .len_eff    (len_eff),
    .use_mask   (use_mask),
    .star_mask  (star_mask),
    .quest_mask (quest_mask),
    .pchar      (pchar),
    .nxt        (step_nxt),
    .matched    (step_match)
  );

  // Advance the state on every character; re-arm on name end or config write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_r <= 1'b1;
    end else if (rearm_req) begin
      fresh_r <= 1'b1;
    end else if (s1_adv) begin
      fresh_r <= s1_end_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && !s1_end_r) begin
      state_r <= step_nxt;
    end
  end

  // Result register: fill on a name-end beat, drop once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_end_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_end_r) begin
      out_matched_r <= step_match;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_matched = out_matched_r;

  // Checks on the pipeline control
  `WNM_ASSERT_NEXT(a_end_rearms, s1_adv && s1_end_r, fresh_r)
  `WNM_ASSERT_SAME(a_result_from_end, $rose(out_valid_r), $past(s1_adv && s1_end_r))
  `WNM_ASSERT_SAME(a_stall_only_on_end, !in_ready,
                   s1_valid_r && s1_end_r && out_valid_r && !out_ready)
  `WNM_ASSERT_NEXT(a_held_result_stays, out_valid_r && !out_ready,
                   out_valid_r && $stable(out_matched_r))

endmodule
